// ===== rtl/usts_pkg.sv =====
package usts_pkg;

    // Table size and the widths that follow from it
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    // Operation codes carried on the kind field
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_REMOVE = 2'd1;
    localparam t_kind KIND_LOOKUP = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_LIMIT = 2'd2
    } t_status;

    // Source of the reported position
    typedef enum logic [1:0] {
        POS_ZERO,
        POS_HIT,
        POS_TAIL,
        POS_SLOT
    } t_pos_sel;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_MOVE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     scan;
        logic     fetch;
        logic     append;
        logic     move;
        logic     report;
        t_status  status;
        t_pos_sel pos_sel;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic dv;
        logic hit;
        logic last;
    } t_dp_stat;

endpackage

// ===== rtl/usts_ctrl.sv =====
module usts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  usts_pkg::t_kind     i_kind,
    input  usts_pkg::t_dp_stat  i_stat,
    output usts_pkg::t_dp_cmd   o_cmd,
    output logic                busy
);

    usts_pkg::t_state r_state, n_state;
    usts_pkg::t_kind  r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= usts_pkg::S_IDLE;
            r_kind  <= usts_pkg::KIND_INSERT;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        o_cmd         = '0;
        o_cmd.status  = usts_pkg::STAT_MISS;
        o_cmd.pos_sel = usts_pkg::POS_ZERO;
        busy          = (r_state != usts_pkg::S_IDLE);

        unique case (r_state)
            usts_pkg::S_IDLE: begin
                if (start) begin
                    n_kind     = i_kind;
                    o_cmd.load = 1'b1;
                    priority if (i_kind == usts_pkg::KIND_INSERT) begin
                        priority if (i_stat.full) begin
                            o_cmd.report = 1'b1;
                            o_cmd.status = usts_pkg::STAT_LIMIT;
                        end else if (i_stat.empty) begin
                            n_state = usts_pkg::S_APPEND;
                        end else begin
                            n_state = usts_pkg::S_SCAN;
                        end
                    end else if (i_kind == usts_pkg::KIND_REMOVE) begin
                        if (i_stat.empty) begin
                            o_cmd.report = 1'b1;
                            o_cmd.status = usts_pkg::STAT_LIMIT;
                        end else begin
                            n_state = usts_pkg::S_SCAN;
                        end
                    end else if (i_kind == usts_pkg::KIND_LOOKUP) begin
                        if (i_stat.empty) begin
                            o_cmd.report = 1'b1;
                        end else begin
                            n_state = usts_pkg::S_SCAN;
                        end
                    end else begin
                        // unused code: no-op, reported as a miss
                        o_cmd.report = 1'b1;
                    end
                end
            end

            usts_pkg::S_SCAN: begin
                priority if (i_stat.dv && i_stat.hit) begin
                    priority if (r_kind == usts_pkg::KIND_REMOVE) begin
                        o_cmd.fetch = 1'b1;
                        n_state     = usts_pkg::S_MOVE;
                    end else begin
                        o_cmd.report  = 1'b1;
                        o_cmd.pos_sel = usts_pkg::POS_HIT;
                        o_cmd.status  = (r_kind == usts_pkg::KIND_INSERT) ?
                                        usts_pkg::STAT_MISS : usts_pkg::STAT_OK;
                        n_state       = usts_pkg::S_IDLE;
                    end
                end else if (i_stat.dv && i_stat.last) begin
                    o_cmd.report = 1'b1;
                    n_state      = usts_pkg::S_IDLE;
                    if (r_kind == usts_pkg::KIND_INSERT) begin
                        o_cmd.append  = 1'b1;
                        o_cmd.status  = usts_pkg::STAT_OK;
                        o_cmd.pos_sel = usts_pkg::POS_TAIL;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end

            usts_pkg::S_APPEND: begin
                o_cmd.append  = 1'b1;
                o_cmd.report  = 1'b1;
                o_cmd.status  = usts_pkg::STAT_OK;
                o_cmd.pos_sel = usts_pkg::POS_TAIL;
                n_state       = usts_pkg::S_IDLE;
            end

            usts_pkg::S_MOVE: begin
                o_cmd.move    = 1'b1;
                o_cmd.report  = 1'b1;
                o_cmd.status  = usts_pkg::STAT_OK;
                o_cmd.pos_sel = usts_pkg::POS_SLOT;
                n_state       = usts_pkg::S_IDLE;
            end

            default: begin
                n_state = usts_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_report_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.report |-> (r_state != usts_pkg::S_IDLE) || start)
        else $error("report issued from idle without an accepted word");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.append && o_cmd.move))
        else $error("append and move in the same cycle");

    a_move_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fetch |=> o_cmd.move)
        else $error("fetch of the tail entry not followed by a move");
`endif

endmodule

// ===== rtl/usts_dp.sv =====
module usts_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  usts_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [usts_pkg::KEY_W-1:0]     i_key,
    output usts_pkg::t_dp_stat                    o_stat,
    output logic                                  o_done,
    output logic [1:0]                            o_status,
    output logic [3:0]                            o_position,
    output logic [4:0]                            o_occupancy
);

    logic signed [usts_pkg::KEY_W-1:0] r_mem [usts_pkg::CAPACITY];
    logic signed [usts_pkg::KEY_W-1:0] r_key;
    logic signed [usts_pkg::KEY_W-1:0] r_rdata;
    logic [usts_pkg::CNT_W-1:0]        r_count, n_count;
    logic [usts_pkg::IDX_W-1:0]        r_ptr;
    logic [usts_pkg::IDX_W-1:0]        r_cidx;
    logic [usts_pkg::IDX_W-1:0]        r_slot;
    logic                              r_dv;
    logic                              r_done;
    logic [1:0]                        r_status;
    logic [3:0]                        r_position;
    logic [4:0]                        r_occupancy;

    logic [usts_pkg::IDX_W-1:0]        tail_idx;
    logic [usts_pkg::IDX_W-1:0]        last_idx;
    logic [usts_pkg::IDX_W-1:0]        rd_addr;
    logic [usts_pkg::IDX_W-1:0]        wr_addr;
    logic signed [usts_pkg::KEY_W-1:0] wr_data;
    logic                              wr_en;
    logic [usts_pkg::IDX_W-1:0]        pos_val;

    assign tail_idx = r_count[usts_pkg::IDX_W-1:0];
    assign last_idx = usts_pkg::IDX_W'(r_count - 1'b1);
    assign rd_addr  = i_cmd.fetch ? last_idx : r_ptr;
    assign wr_en    = i_cmd.append || i_cmd.move;
    assign wr_addr  = i_cmd.append ? tail_idx : r_slot;
    assign wr_data  = i_cmd.append ? r_key : r_rdata;

    always_comb begin
        n_count = r_count;
        if (i_cmd.append) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.move) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        unique case (i_cmd.pos_sel)
            usts_pkg::POS_ZERO: pos_val = '0;
            usts_pkg::POS_HIT:  pos_val = r_cidx;
            usts_pkg::POS_TAIL: pos_val = tail_idx;
            usts_pkg::POS_SLOT: pos_val = r_slot;
            default:            pos_val = '0;
        endcase
    end

    assign o_stat.full  = (r_count == usts_pkg::CNT_W'(usts_pkg::CAPACITY));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.dv    = r_dv;
    assign o_stat.hit   = (r_rdata == r_key);
    assign o_stat.last  = (r_cidx == last_idx);

    // key store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_dv    <= i_cmd.scan;
            r_done  <= i_cmd.report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
            r_ptr <= '0;
        end else if (i_cmd.scan) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.scan) begin
            r_cidx <= r_ptr;
        end
        if (r_dv && o_stat.hit) begin
            r_slot <= r_cidx;
        end
        if (i_cmd.report) begin
            r_status    <= i_cmd.status;
            r_position  <= 4'(pos_val);
            r_occupancy <= 5'(n_count);
        end
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_position  = r_position;
    assign o_occupancy = r_occupancy;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= usts_pkg::CNT_W'(usts_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_no_append_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> !o_stat.full)
        else $error("append into a full table");

    a_no_move_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move |-> !o_stat.empty)
        else $error("move on an empty table");
`endif

endmodule

// ===== rtl/unique_key_set_table.sv =====
// Channel  | Ports                                 | Handshake
// ---------+---------------------------------------+------------------------------------
// command  | i_kind[1:0], i_key[31:0] signed       | taken when start && !busy
// result   | o_status[1:0], o_position[3:0],       | o_done high for exactly one cycle
//          | o_occupancy[4:0]                      |
//
// One word per command. The result word shows up in the first cycle with busy low again.
// Scans read one stored key per cycle through the registered read port, so a lookup,
// an insert or a missed remove holds busy while it walks the occupied entries; a remove
// that hits then moves the tail entry down into the freed slot before it answers.
// Refusals, the unused code and a lookup on an empty table never raise busy.
// Synchronous reset empties the table; the receiver cannot stall.
module unique_key_set_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_key,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [3:0]         o_position,
    output logic [4:0]         o_occupancy
);

    usts_pkg::t_dp_cmd  cmd;
    usts_pkg::t_dp_stat stat;

    // Controller: sequence the scan, append and tail move
    usts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Datapath: key store, count, scan pointer and result registers
    usts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_key       (i_key),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_occupancy (o_occupancy)
    );

`ifndef SYNTH
    a_done_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($fell(busy) || $past(start && !busy)))
        else $error("result word without a finished command");

    a_limit_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == usts_pkg::STAT_LIMIT) |-> (o_position == '0))
        else $error("refused command reports a nonzero position");

    a_busy_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("command finished without a result word");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;

    // The kind field has one code with no operation behind it; the block must answer
    // it as a miss and leave the table alone.
    localparam usts_pkg::t_kind KIND_NONE = 2'd3;

    // One expected result word.
    typedef struct {
        usts_pkg::t_status                status;
        logic [usts_pkg::IDX_W-1:0]       position;
        logic [usts_pkg::CNT_W-1:0]       occupancy;
    } t_outcome;

    // Shadow copy of the key table. It predicts each result at the moment its command
    // is accepted and holds the predictions in order until the block answers.
    class t_key_table_shadow;
        logic [usts_pkg::KEY_W-1:0] held [usts_pkg::CAPACITY];
        int unsigned      held_count;
        t_outcome         awaited[$];
        int unsigned      failures;
        int unsigned      kind_seen [4];
        int unsigned      full_refusals;
        int unsigned      empty_refusals;
        int unsigned      peak_count;

        function new();
            held_count = 0;
            failures   = 0;
            full_refusals  = 0;
            empty_refusals = 0;
            peak_count     = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        // Scan only the occupied slots; the rest hold stale or unwritten keys.
        function bit locate(logic [usts_pkg::KEY_W-1:0] key, output int unsigned slot);
            slot = 0;
            for (int unsigned s = 0; s < held_count; s++) begin
                if (held[s] == key) begin
                    slot = s;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function logic [usts_pkg::KEY_W-1:0] any_held_key();
            return held[$urandom_range(held_count - 1)];
        endfunction

        function void note_command(usts_pkg::t_kind kind, logic [usts_pkg::KEY_W-1:0] key);
            t_outcome    want;
            int unsigned slot;
            bit          hit;
            want.status   = usts_pkg::STAT_MISS;
            want.position = '0;
            hit = locate(key, slot);
            kind_seen[kind]++;
            case (kind)
                usts_pkg::KIND_INSERT: begin
                    if (held_count >= usts_pkg::CAPACITY) begin
                        want.status = usts_pkg::STAT_LIMIT;
                        full_refusals++;
                    end else if (hit) begin
                        want.position = slot[usts_pkg::IDX_W-1:0];
                    end else begin
                        held[held_count] = key;
                        want.position    = held_count[usts_pkg::IDX_W-1:0];
                        held_count++;
                        want.status = usts_pkg::STAT_OK;
                    end
                end
                usts_pkg::KIND_REMOVE: begin
                    if (held_count == 0) begin
                        want.status = usts_pkg::STAT_LIMIT;
                        empty_refusals++;
                    end else if (hit) begin
                        held_count--;
                        held[slot]    = held[held_count];
                        want.position = slot[usts_pkg::IDX_W-1:0];
                        want.status   = usts_pkg::STAT_OK;
                    end
                end
                usts_pkg::KIND_LOOKUP: begin
                    if (hit) begin
                        want.status   = usts_pkg::STAT_OK;
                        want.position = slot[usts_pkg::IDX_W-1:0];
                    end
                end
                default: ;
            endcase
            want.occupancy = held_count[usts_pkg::CNT_W-1:0];
            if (held_count > peak_count) peak_count = held_count;
            awaited.push_back(want);
        endfunction

        function void check_outcome(logic [1:0] status,
                                    logic [usts_pkg::IDX_W-1:0] position,
                                    logic [usts_pkg::CNT_W-1:0] occupancy);
            t_outcome want;
            if (awaited.size() == 0) begin
                $error("%s: status %0d position %0d occupancy %0d",
                       "result word with no command outstanding",
                       status, position, occupancy);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                failures++;
            end
            if (position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, position);
                failures++;
            end
            if (occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                failures++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 i_kind;
    logic [usts_pkg::KEY_W-1:0] i_key;
    logic                       o_done;
    logic [1:0]                 o_status;
    logic [usts_pkg::IDX_W-1:0] o_position;
    logic [usts_pkg::CNT_W-1:0] o_occupancy;

    t_key_table_shadow table_shadow;
    int unsigned       sender_idle_pct;

    unique_key_set_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_occupancy (o_occupancy)
    );

    // 4-unit clock period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Every result word lives for one cycle only, so sample it on each rising edge
    // it is marked. Inputs move on the falling edge, so nothing races here.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            table_shadow.check_outcome(o_status, o_position, o_occupancy);
        end
    end

    // Hand one command word to the block. Idle first at the current sender rate,
    // with junk on the fields while start is low, then hold the word until busy is
    // seen low on a falling edge; the next rising edge takes it. Record the word in
    // the shadow at that edge, so the next key choice already sees its effect.
    task automatic send_word(usts_pkg::t_kind kind, logic [usts_pkg::KEY_W-1:0] key);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start  <= 1'b0;
            i_kind <= 2'($urandom);
            i_key  <= $urandom;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_kind <= kind;
        i_key  <= key;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        table_shadow.note_command(kind, key);
    endtask

    // Keys that tend to collide: the extremes of the signed range, the alternating
    // patterns and a handful of small values of either sign.
    function automatic logic [usts_pkg::KEY_W-1:0] pool_key();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h5555_5555;
            3: return 32'hAAAA_AAAA;
            4: return 32'($urandom_range(15)) - 32'd8;
            default: return 32'($urandom_range(40));
        endcase
    endfunction

    // Pick a key: mostly one already held when a hit is wanted, otherwise a
    // colliding pool key or a fully random pattern.
    function automatic logic [usts_pkg::KEY_W-1:0] pick_key(int unsigned held_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (table_shadow.held_count > 0 && roll < held_pct) return table_shadow.any_held_key();
        if ($urandom_range(1)) return pool_key();
        return $urandom;
    endfunction

    // Short walk over the corner cases: a lookup and a refused remove on an empty table, the extreme
    // keys, a duplicate insert, misses, removing the first slot so the last entry
    // moves down, removing the last slot, and the unused kind code.
    task automatic run_directed();
        send_word(usts_pkg::KIND_LOOKUP, 32'h0000_0000);
        send_word(usts_pkg::KIND_REMOVE, 32'h0000_0000);
        send_word(KIND_NONE,             32'hFFFF_FFFF);
        send_word(usts_pkg::KIND_INSERT, 32'h8000_0000);
        send_word(usts_pkg::KIND_INSERT, 32'h7FFF_FFFF);
        send_word(usts_pkg::KIND_INSERT, 32'h0000_0000);
        send_word(usts_pkg::KIND_INSERT, 32'hFFFF_FFFF);
        send_word(usts_pkg::KIND_INSERT, 32'h7FFF_FFFF);
        send_word(usts_pkg::KIND_LOOKUP, 32'hFFFF_FFFF);
        send_word(usts_pkg::KIND_LOOKUP, 32'h0001_2345);
        send_word(usts_pkg::KIND_REMOVE, 32'h0000_0005);
        send_word(usts_pkg::KIND_REMOVE, 32'h8000_0000);
        send_word(usts_pkg::KIND_LOOKUP, 32'hFFFF_FFFF);
        send_word(usts_pkg::KIND_REMOVE, 32'h0000_0000);
        send_word(KIND_NONE,             32'h0000_0000);
        send_word(usts_pkg::KIND_LOOKUP, 32'h8000_0000);
        send_word(usts_pkg::KIND_REMOVE, 32'h7FFF_FFFF);
        send_word(usts_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
        send_word(usts_pkg::KIND_LOOKUP, 32'hFFFF_FFFF);
        send_word(usts_pkg::KIND_REMOVE, 32'h8000_0000);
        send_word(usts_pkg::KIND_INSERT, 32'hFFFF_FFFF);
    endtask

    // Random traffic in bursts. Each burst leans one way: fill pushes the table to
    // full and keeps knocking on it, drain empties it and keeps removing, mixed
    // stirs everything. Hits dominate lookups and removes so the scan runs deep.
    task automatic run_random(int unsigned words, int unsigned idle_pct);
        int unsigned     mode;
        int unsigned     burst;
        int unsigned     roll;
        usts_pkg::t_kind kind;
        sender_idle_pct = idle_pct;
        while (words > 0) begin
            mode  = $urandom_range(2);
            burst = $urandom_range(40, 6);
            if (burst > words) burst = words;
            words -= burst;
            repeat (burst) begin
                roll = $urandom_range(99);
                if (roll < 3) begin
                    kind = KIND_NONE;
                end else if (mode == 0) begin
                    if (roll < 75)      kind = usts_pkg::KIND_INSERT;
                    else if (roll < 88) kind = usts_pkg::KIND_LOOKUP;
                    else                kind = usts_pkg::KIND_REMOVE;
                end else if (mode == 1) begin
                    if (roll < 70)      kind = usts_pkg::KIND_REMOVE;
                    else if (roll < 85) kind = usts_pkg::KIND_LOOKUP;
                    else                kind = usts_pkg::KIND_INSERT;
                end else begin
                    if (roll < 36)      kind = usts_pkg::KIND_INSERT;
                    else if (roll < 68) kind = usts_pkg::KIND_REMOVE;
                    else                kind = usts_pkg::KIND_LOOKUP;
                end
                send_word(kind, pick_key(kind == usts_pkg::KIND_INSERT ? 15 : 75));
            end
        end
    endtask

    initial begin
        table_shadow    = new();
        sender_idle_pct = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_kind  = '0;
        i_key   = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        // Sender idles lightly, then heavily, then never.
        run_random(250, 13);
        run_random(250, 47);
        run_random(250, 0);
        @(negedge i_clk);
        start <= 1'b0;

        // Drain: let outstanding results arrive, then watch for stray words.
        for (int n = 0; n < 200 && table_shadow.awaited.size() > 0; n++) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (table_shadow.awaited.size() > 0) begin
            $error("%0d expected result words never arrived", table_shadow.awaited.size());
            table_shadow.failures++;
        end

        $display("Ran %0d inserts, %0d removes, %0d lookups and %0d no-op words;",
                 table_shadow.kind_seen[usts_pkg::KIND_INSERT],
                 table_shadow.kind_seen[usts_pkg::KIND_REMOVE],
                 table_shadow.kind_seen[usts_pkg::KIND_LOOKUP],
                 table_shadow.kind_seen[KIND_NONE]);
        $display("peak occupancy %0d, %0d full-table inserts and %0d empty-table removes refused.",
                 table_shadow.peak_count, table_shadow.full_refusals,
                 table_shadow.empty_refusals);
        if (table_shadow.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== unique_key_set_table.f =====
rtl/usts_pkg.sv
rtl/usts_ctrl.sv
rtl/usts_dp.sv
rtl/unique_key_set_table.sv
tb/tb.sv
